[rtl/bb3_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types and constants of the 3x3 RGB box blur: pixel, window column,
// column sums, beat structs, configuration register indexes.
// ----------------------------------------------------------------------------
package bb3_pkg;

  // Default size limits of the frame
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;

  // Register reset values
  localparam int WIDTH_RST  = 1024;
  localparam int HEIGHT_RST = 768;

  // Configuration port
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IMG_W  = 11;
  localparam int CFG_IMG_H  = 13;

  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } bb3_cfg_idx_t;

  // Field widths of the result beat
  localparam int OUT_COL_W = 10;
  localparam int OUT_ROW_W = 12;

  // Divide by 9: floor(s * 3641 / 2^15) is exact for s <= 9 * 255
  localparam int SUM_W  = 12;
  localparam int QMUL   = 3641;
  localparam int QSHIFT = 15;
  localparam int PROD_W = 24;

  // Result queue
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = 4;
  localparam int RES_MAX    = 3;
  localparam int FILL_W     = FIFO_AW + 2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } bb3_pix_t;

  // One window column: rows r-2, r-1, r
  typedef struct packed {
    bb3_pix_t top;
    bb3_pix_t mid;
    bb3_pix_t bot;
  } bb3_col_t;

  // Per-channel sum of one column (3 x 255 max)
  typedef struct packed {
    logic [9:0] red;
    logic [9:0] green;
    logic [9:0] blue;
  } bb3_csum_t;

  // Per-channel sum of the full window (9 x 255 max)
  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } bb3_wsum_t;

  // Line buffer word: rows r-2 and r-1 of one column
  typedef struct packed {
    bb3_pix_t older;
    bb3_pix_t newer;
  } bb3_line_t;

  // Position flags of one pixel
  typedef struct packed {
    logic r_ge1;
    logic r_ge2;
    logic c_ge1;
    logic c_ge2;
    logic last_col;
    logic last_row;
  } bb3_flags_t;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } bb3_in_t;

  typedef struct packed {
    logic [7:0]           out_red;
    logic [7:0]           out_green;
    logic [7:0]           out_blue;
    logic [OUT_COL_W-1:0] out_col;
    logic [OUT_ROW_W-1:0] out_row;
    logic                 run_last;
  } bb3_out_t;

endpackage

[rtl/box_blur_3x3_rgb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// Streaming 3x3 box blur over RGB frames in raster order. Interior pixels
// become the per-channel window mean (truncated); border pixels pass through.
// ----------------------------------------------------------------------------
//
//   port group   dir   handshake          beat
//   in_*         in    in_valid/in_ready  one pixel (bb3_in_t)
//   out_*        out   out_valid/out_ready one result pixel (bb3_out_t)
//   cfg_*        in    cfg_we             image_width / image_height write
//
// One pixel per clock is accepted while each pixel yields at most one result;
// pixels of the last column or the last row can yield up to three, and the single
// output port (one beat per clock) then sets the pace.
// A result passes line buffer read, window column load, window sum and
// divide by 9 in turn. The 16-entry result queue is guarded by credit,
// so a stalled output throttles in_ready and nothing is dropped.
// Reset clears counters and control; line buffers need no clearing pass.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb
  import bb3_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bb3_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bb3_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int W_RST = (WIDTH_RST < MAX_WIDTH) ? WIDTH_RST : MAX_WIDTH;
  localparam int H_RST = (HEIGHT_RST < MAX_HEIGHT) ? HEIGHT_RST : MAX_HEIGHT;

  typedef struct packed {
    logic [CW-1:0] col;
    logic [RW-1:0] row;
    bb3_pix_t      pix;
    bb3_flags_t    flags;
  } info_t;

  // --------------------------------------------------------------------------
  // Configuration: store last column / last row, already clamped
  // --------------------------------------------------------------------------
  logic [CW-1:0]        col_last_r, col_last_nxt;
  logic [RW-1:0]        row_last_r, row_last_nxt;
  logic [CFG_IMG_W-1:0] cfg_w;
  logic [CFG_IMG_H-1:0] cfg_h;

  assign cfg_w = cfg_data[CFG_IMG_W-1:0];
  assign cfg_h = cfg_data[CFG_IMG_H-1:0];

  always_comb begin
    col_last_nxt = col_last_r;
    row_last_nxt = row_last_r;
    if (cfg_we) begin
      case (bb3_cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH: begin
          if (cfg_w == '0) begin
            col_last_nxt = '0;
          end else if (32'(cfg_w) > MAX_WIDTH) begin
            col_last_nxt = CW'(MAX_WIDTH - 1);
          end else begin
            col_last_nxt = CW'(cfg_w - CFG_IMG_W'(1));
          end
        end
        CFG_IMAGE_HEIGHT: begin
          if (cfg_h == '0) begin
            row_last_nxt = '0;
          end else if (32'(cfg_h) > MAX_HEIGHT) begin
            row_last_nxt = RW'(MAX_HEIGHT - 1);
          end else begin
            row_last_nxt = RW'(cfg_h - CFG_IMG_H'(1));
          end
        end
        default: begin
          col_last_nxt = col_last_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_last_r <= CW'(W_RST - 1);
      row_last_r <= RW'(H_RST - 1);
    end else begin
      col_last_r <= col_last_nxt;
      row_last_r <= row_last_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Accept stage: position of the pixel, counters
  // --------------------------------------------------------------------------
  logic          in_fire;
  logic [CW-1:0] col_cnt_r, col_cnt_nxt;
  logic [RW-1:0] row_cnt_r, row_cnt_nxt;
  logic [CW-1:0] c0;
  logic [RW-1:0] r0;
  info_t         info0;

  assign in_fire = in_valid && in_ready;

  // Saturate counters that lie past a shrunken frame
  assign c0 = (col_cnt_r > col_last_r) ? col_last_r : col_cnt_r;
  assign r0 = (row_cnt_r > row_last_r) ? row_last_r : row_cnt_r;

  always_comb begin
    info0.col            = c0;
    info0.row            = r0;
    info0.pix.red        = in_data.in_red;
    info0.pix.green      = in_data.in_green;
    info0.pix.blue       = in_data.in_blue;
    info0.flags.r_ge1    = (r0 != '0);
    info0.flags.r_ge2    = (r0 > RW'(1));
    info0.flags.c_ge1    = (c0 != '0);
    info0.flags.c_ge2    = (c0 > CW'(1));
    info0.flags.last_col = (c0 == col_last_r);
    info0.flags.last_row = (r0 == row_last_r);
  end

  // Column wraps at end of row, row wraps at end of frame
  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (in_fire) begin
      if (info0.flags.last_col) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = info0.flags.last_row ? '0 : r0 + RW'(1);
      end else begin
        col_cnt_nxt = c0 + CW'(1);
        row_cnt_nxt = r0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: s1 window load, s2 window sum, s3 divide and emit
  // --------------------------------------------------------------------------
  logic  v1_r, v2_r, v3_r;
  info_t s1_r, s2_r, s3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_fire;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= info0;
    end
    s2_r <= s1_r;
    s3_r <= s2_r;
  end

  // --------------------------------------------------------------------------
  // Line buffers
  // --------------------------------------------------------------------------
  bb3_pix_t top_pix, mid_pix;

  bb3_line_buf #(
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (c0),
    .wr_en   (v1_r),
    .wr_addr (s1_r.col),
    .wr_pix  (s1_r.pix),
    .top_pix (top_pix),
    .mid_pix (mid_pix)
  );

  // --------------------------------------------------------------------------
  // Window: chain of three column cells, newest on the right
  // --------------------------------------------------------------------------
  bb3_col_t  col_in_w [3];
  bb3_col_t  col_q    [3];
  bb3_csum_t csum_q   [3];

  assign col_in_w[2].top = top_pix;
  assign col_in_w[2].mid = mid_pix;
  assign col_in_w[2].bot = s1_r.pix;

  for (genvar j = 0; j < 3; j++) begin : g_cell
    if (j < 2) begin : g_link
      assign col_in_w[j] = col_q[j+1];
    end
    bb3_cell u_cell (
      .clk      (clk),
      .shift_en (v1_r),
      .col_in   (col_in_w[j]),
      .col_out  (col_q[j]),
      .sum_out  (csum_q[j])
    );
  end

  // --------------------------------------------------------------------------
  // s2: window sum, keep center and right-middle pixels
  // --------------------------------------------------------------------------
  bb3_wsum_t wsum, wsum_r;
  bb3_pix_t  center_r, rmid_r;

  always_comb begin
    wsum.red   = SUM_W'(csum_q[0].red)   + SUM_W'(csum_q[1].red)   + SUM_W'(csum_q[2].red);
    wsum.green = SUM_W'(csum_q[0].green) + SUM_W'(csum_q[1].green) + SUM_W'(csum_q[2].green);
    wsum.blue  = SUM_W'(csum_q[0].blue)  + SUM_W'(csum_q[1].blue)  + SUM_W'(csum_q[2].blue);
  end

  always_ff @(posedge clk) begin
    wsum_r   <= wsum;
    center_r <= col_q[1].mid;
    rmid_r   <= col_q[2].mid;
  end

  // --------------------------------------------------------------------------
  // s3: divide by 9 through reciprocal multiply, form results
  // --------------------------------------------------------------------------
  logic [PROD_W-1:0]     prod_r, prod_g, prod_b;
  bb3_pix_t              mean;
  logic [RES_MAX-1:0]    res_vld;
  bb3_out_t [RES_MAX-1:0] res;
  bb3_pix_t              pix_a;

  always_comb begin
    prod_r = PROD_W'(wsum_r.red)   * PROD_W'(QMUL);
    prod_g = PROD_W'(wsum_r.green) * PROD_W'(QMUL);
    prod_b = PROD_W'(wsum_r.blue)  * PROD_W'(QMUL);
    mean.red   = prod_r[QSHIFT +: 8];
    mean.green = prod_g[QSHIFT +: 8];
    mean.blue  = prod_b[QSHIFT +: 8];
  end

  always_comb begin
    // Pixel one row up and one column left: blurred inside, else passed
    pix_a = (s3_r.flags.r_ge2 && s3_r.flags.c_ge2) ? mean : center_r;

    res_vld[0] = v3_r && s3_r.flags.r_ge1 && s3_r.flags.c_ge1;
    res_vld[1] = v3_r && s3_r.flags.r_ge1 && s3_r.flags.last_col;
    res_vld[2] = v3_r && s3_r.flags.last_row;

    res[0].out_red   = pix_a.red;
    res[0].out_green = pix_a.green;
    res[0].out_blue  = pix_a.blue;
    res[0].out_col   = OUT_COL_W'(s3_r.col - CW'(1));
    res[0].out_row   = OUT_ROW_W'(s3_r.row - RW'(1));
    res[0].run_last  = !res_vld[1] && !res_vld[2];

    // Last column of the row above, passed through
    res[1].out_red   = rmid_r.red;
    res[1].out_green = rmid_r.green;
    res[1].out_blue  = rmid_r.blue;
    res[1].out_col   = OUT_COL_W'(s3_r.col);
    res[1].out_row   = OUT_ROW_W'(s3_r.row - RW'(1));
    res[1].run_last  = !res_vld[2];

    // Last row: the pixel itself, passed through
    res[2].out_red   = s3_r.pix.red;
    res[2].out_green = s3_r.pix.green;
    res[2].out_blue  = s3_r.pix.blue;
    res[2].out_col   = OUT_COL_W'(s3_r.col);
    res[2].out_row   = OUT_ROW_W'(s3_r.row);
    res[2].run_last  = 1'b1;
  end

  // --------------------------------------------------------------------------
  // Result queue and input credit
  // --------------------------------------------------------------------------
  logic [FIFO_AW:0] fifo_cnt;
  logic [1:0]       inflight;
  logic [FILL_W-1:0] fill;

  bb3_out_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_vld   (res_vld),
    .wr_data  (res),
    .rd_valid (out_valid),
    .rd_ready (out_ready),
    .rd_data  (out_data),
    .count    (fifo_cnt)
  );

  // Every pixel in flight may still add RES_MAX beats
  assign inflight = 2'(v1_r) + 2'(v2_r) + 2'(v3_r);
  assign fill     = FILL_W'(fifo_cnt) + FILL_W'(inflight) * FILL_W'(RES_MAX);
  assign in_ready = (fill <= FILL_W'(FIFO_DEPTH - RES_MAX));

endmodule

[rtl/bb3_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_cell
// One column of the 3x3 window. Loads its column on each pixel (newest cell:
// from line buffer, others: from neighbor), keeps its per-channel column sum.
// ----------------------------------------------------------------------------
module bb3_cell
  import bb3_pkg::*;
(
  input  logic      clk,
  input  logic      shift_en,
  input  bb3_col_t  col_in,
  output bb3_col_t  col_out,
  output bb3_csum_t sum_out
);

  bb3_col_t  col_r;
  bb3_csum_t sum_r;
  bb3_csum_t sum_nxt;

  // Column sum of the incoming column
  always_comb begin
    sum_nxt.red   = 10'(col_in.top.red)   + 10'(col_in.mid.red)   + 10'(col_in.bot.red);
    sum_nxt.green = 10'(col_in.top.green) + 10'(col_in.mid.green) + 10'(col_in.bot.green);
    sum_nxt.blue  = 10'(col_in.top.blue)  + 10'(col_in.mid.blue)  + 10'(col_in.bot.blue);
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      col_r <= col_in;
      sum_r <= sum_nxt;
    end
  end

  assign col_out = col_r;
  assign sum_out = sum_r;

endmodule

[rtl/bb3_line_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_line_buf
// Two line buffers in one memory word per column. Read on pixel accept,
// written back in the next cycle; a read that meets the write of the previous
// pixel at the same column takes the forwarded word.
// ----------------------------------------------------------------------------
module bb3_line_buf
  import bb3_pkg::*;
#(
  parameter int DEPTH = MAX_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  bb3_pix_t                 wr_pix,
  output bb3_pix_t                 top_pix,
  output bb3_pix_t                 mid_pix
);

  bb3_line_t mem [DEPTH];
  bb3_line_t rd_data_r;
  bb3_line_t last_r;
  logic      fwd_r;
  bb3_line_t cur;
  bb3_line_t wr_word;

  // Column word seen by the pixel now in the write stage
  assign cur = fwd_r ? last_r : rd_data_r;

  // Shift the column: r-1 moves to r-2, the new pixel becomes r-1
  assign wr_word.older = cur.newer;
  assign wr_word.newer = wr_pix;

  assign top_pix = cur.older;
  assign mid_pix = cur.newer;

  // Memory: read-first, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
      last_r       <= wr_word;
    end
  end

  // Forward flag for a read that collides with this cycle's write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

endmodule

[rtl/bb3_out_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_out_fifo
// Result queue. Takes up to three result beats per cycle, packed in order,
// and hands out one beat per cycle on a valid/ready port.
// ----------------------------------------------------------------------------
module bb3_out_fifo
  import bb3_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [RES_MAX-1:0]   wr_vld,
  input  bb3_out_t [RES_MAX-1:0] wr_data,
  output logic                 rd_valid,
  input  logic                 rd_ready,
  output bb3_out_t             rd_data,
  output logic [FIFO_AW:0]     count
);

  bb3_out_t           mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;
  logic [FIFO_AW-1:0] off [RES_MAX];
  logic [FIFO_AW-1:0] n_push;
  logic               pop;

  // Slot offsets so valid beats land back to back
  always_comb begin
    off[0] = '0;
    for (int i = 1; i < RES_MAX; i++) begin
      off[i] = off[i-1] + FIFO_AW'(wr_vld[i-1]);
    end
    n_push = off[RES_MAX-1] + FIFO_AW'(wr_vld[RES_MAX-1]);
  end

  assign pop        = rd_valid && rd_ready;
  assign wr_ptr_nxt = wr_ptr_r + n_push;
  assign rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
  assign cnt_nxt    = cnt_r + (FIFO_AW + 1)'(n_push) - (FIFO_AW + 1)'(pop);

  // Storage
  always_ff @(posedge clk) begin
    for (int i = 0; i < RES_MAX; i++) begin
      if (wr_vld[i]) begin
        mem[wr_ptr_r + off[i]] <= wr_data[i];
      end
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem[rd_ptr_r];
  assign count    = cnt_r;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming 3x3 RGB box blur. A driver pushes
// raster-order pixels from a queue and a monitor drains result beats, both
// with random idle gaps. A predictor computes the result beats
// of every accepted pixel, and the monitor compares them field by field.
// Frame sizes change between phases: tiny and clamped sizes, and mid-frame
// shrinks that make the counters saturate.
// ----------------------------------------------------------------------------
module testbench;
  import bb3_pkg::*;

  localparam int          MAX_W         = MAX_WIDTH_DEF;
  localparam int          MAX_H         = MAX_HEIGHT_DEF;
  localparam int          CLK_HALF      = 2;
  localparam int          RESET_CYCLES  = 8;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          RANDOM_PIXELS = 175;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;

  // Corner-case frame, 4 x 3: the first interior window is all 255
  localparam logic [23:0] CORNER_FRAME [12] = '{
    24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h000000,
    24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h00FF00,
    24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hAA55AA
  };

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  bb3_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  bb3_out_t              out_data;
  logic                  cfg_we    = 1'b0;
  bb3_cfg_idx_t          cfg_index = CFG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Predictor state: two previous rows, 3x3 neighborhood, position, size
  bb3_pix_t              prev2_row [MAX_W];
  bb3_pix_t              prev1_row [MAX_W];
  bb3_pix_t              nbhd [9];
  logic [OUT_COL_W-1:0]  col_pos;
  logic [OUT_ROW_W-1:0]  row_pos;
  logic [CFG_IMG_W-1:0]  frame_w_reg;
  logic [CFG_IMG_H-1:0]  frame_h_reg;

  bb3_in_t               pixel_feed [$];
  bb3_out_t              predicted_px [$];
  bb3_out_t              want;

  int unsigned           pushed_cnt    = 0;
  int unsigned           taken_cnt     = 0;
  int unsigned           checked_cnt   = 0;
  int unsigned           blurred_cnt   = 0;
  int unsigned           settings_cnt  = 0;
  int unsigned           fail_cnt      = 0;
  int unsigned           cycle_cnt     = 0;
  int unsigned           send_holdoff  = 0;
  int unsigned           recv_stall    = 0;
  bit                    calm_in       = 1'b0;
  bit                    calm_out      = 1'b0;

  box_blur_3x3_rgb u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Size register as the block uses it: zero reads as one, large ones clamp
  function automatic int unsigned eff_size(int unsigned raw, int unsigned hi);
    if (raw == 0) return 1;
    if (raw > hi) return hi;
    return raw;
  endfunction

  // Effective size and position, counters saturated to the current size
  function automatic void frame_geom(output int unsigned w, output int unsigned h,
                                     output int unsigned c, output int unsigned r);
    w = eff_size(frame_w_reg, MAX_W);
    h = eff_size(frame_h_reg, MAX_H);
    c = (col_pos > w - 1) ? w - 1 : col_pos;
    r = (row_pos > h - 1) ? h - 1 : row_pos;
  endfunction

  function automatic int unsigned pixels_to_frame_end();
    int unsigned w, h, c, r;
    frame_geom(w, h, c, r);
    return (h - 1 - r) * w + (w - 1 - c) + 1;
  endfunction

  function automatic bb3_out_t make_beat(bb3_pix_t p, int unsigned col, int unsigned row);
    bb3_out_t b;
    b.out_red   = p.red;
    b.out_green = p.green;
    b.out_blue  = p.blue;
    b.out_col   = col[OUT_COL_W-1:0];
    b.out_row   = row[OUT_ROW_W-1:0];
    b.run_last  = 1'b0;
    return b;
  endfunction

  // Advance the predictor by one pixel and queue the beats it causes
  function automatic void blur_step(bb3_in_t px);
    int unsigned w, h, c, r, k;
    int unsigned s_red, s_green, s_blue;
    bb3_pix_t    cur, top, mid, v;
    bb3_out_t    beats [$];
    frame_geom(w, h, c, r);
    cur = '{px.in_red, px.in_green, px.in_blue};
    top = prev2_row[c];
    mid = prev1_row[c];
    prev2_row[c] = mid;
    prev1_row[c] = cur;

    for (k = 0; k < 3; k++) begin
      nbhd[3*k]     = nbhd[3*k + 1];
      nbhd[3*k + 1] = nbhd[3*k + 2];
    end
    nbhd[2] = top;
    nbhd[5] = mid;
    nbhd[8] = cur;

    // Pixel one row up and one column left: blurred if interior
    if (r >= 1 && c >= 1) begin
      if (r >= 2 && c >= 2) begin
        s_red   = 0;
        s_green = 0;
        s_blue  = 0;
        for (k = 0; k < 9; k++) begin
          s_red   += nbhd[k].red;
          s_green += nbhd[k].green;
          s_blue  += nbhd[k].blue;
        end
        v.red   = 8'(s_red / 9);
        v.green = 8'(s_green / 9);
        v.blue  = 8'(s_blue / 9);
        blurred_cnt++;
      end else begin
        v = nbhd[4];
      end
      beats.push_back(make_beat(v, c - 1, r - 1));
    end
    // Right border of the row above
    if (r >= 1 && c == w - 1) beats.push_back(make_beat(nbhd[5], c, r - 1));
    // Bottom row passes straight through
    if (r == h - 1) beats.push_back(make_beat(cur, c, r));
    if (beats.size() > 0) beats[beats.size() - 1].run_last = 1'b1;
    foreach (beats[i]) predicted_px.push_back(beats[i]);

    if (c >= w - 1) begin
      col_pos = '0;
      row_pos = (r >= h - 1) ? '0 : OUT_ROW_W'(r + 1);
    end else begin
      col_pos = OUT_COL_W'(c + 1);
      row_pos = OUT_ROW_W'(r);
    end
  endfunction

  // Idle length: mostly none, some short, a few long
  function automatic int unsigned pick_idle(bit calm);
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic flag_mismatch(string field, logic [31:0] exp_v, logic [31:0] got_v);
    fail_cnt++;
    $error("%s mismatch: expected %0d, got %0d", field, exp_v, got_v);
  endtask

  task automatic feed_const(logic [23:0] rgb);
    pixel_feed.push_back(bb3_in_t'(rgb));
    pushed_cnt++;
  endtask

  task automatic feed_random(int unsigned n);
    repeat (n) feed_const(24'($urandom));
  endtask

  // Wait until every pixel is taken and every beat has come back
  task automatic drain();
    while (!(taken_cnt == pushed_cnt && predicted_px.size() == 0)) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(bb3_cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IMAGE_WIDTH) frame_w_reg = val[CFG_IMG_W-1:0];
    else frame_h_reg = val[CFG_IMG_H-1:0];
  endtask

  // New phase: drain, pick idle style, program both size registers
  task automatic set_size(int unsigned w_raw, int unsigned h_raw);
    drain();
    calm_in  = ($urandom_range(0, 3) == 0);
    calm_out = ($urandom_range(0, 3) == 0);
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w_raw));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h_raw));
    settings_cnt++;
  endtask

  // Input driver: one beat at a time from the pixel queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        blur_step(in_data);
        taken_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (send_holdoff > 0) begin
          send_holdoff--;
          in_valid <= 1'b0;
        end else if (pixel_feed.size() > 0) begin
          in_data      <= pixel_feed.pop_front();
          in_valid     <= 1'b1;
          send_holdoff = pick_idle(calm_in);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        checked_cnt++;
        if (predicted_px.size() == 0) begin
          fail_cnt++;
          $error("unexpected result beat at col %0d row %0d",
                 out_data.out_col, out_data.out_row);
        end else begin
          want = predicted_px.pop_front();
          if (out_data.out_red !== want.out_red)
            flag_mismatch("out_red", want.out_red, out_data.out_red);
          if (out_data.out_green !== want.out_green)
            flag_mismatch("out_green", want.out_green, out_data.out_green);
          if (out_data.out_blue !== want.out_blue)
            flag_mismatch("out_blue", want.out_blue, out_data.out_blue);
          if (out_data.out_col !== want.out_col)
            flag_mismatch("out_col", want.out_col, out_data.out_col);
          if (out_data.out_row !== want.out_row)
            flag_mismatch("out_row", want.out_row, out_data.out_row);
          if (out_data.run_last !== want.run_last)
            flag_mismatch("run_last", want.run_last, out_data.run_last);
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready  <= 1'b1;
        recv_stall = pick_idle(calm_out);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin
    int unsigned w, h, c, r, new_w, new_h, n, random_px;
    bit          at_start;

    for (int i = 0; i < MAX_W; i++) begin
      prev2_row[i] = '0;
      prev1_row[i] = '0;
    end
    foreach (nbhd[i]) nbhd[i] = '0;
    col_pos     = '0;
    row_pos     = '0;
    frame_w_reg = CFG_IMG_W'(WIDTH_RST);
    frame_h_reg = CFG_IMG_H'(HEIGHT_RST);
    random_px   = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Small frame with an interior: saturated and mixed windows
    set_size(4, 3);
    foreach (CORNER_FRAME[i]) feed_const(CORNER_FRAME[i]);

    // Zero sizes behave as 1 x 1: every pixel passes through
    set_size(0, 0);
    feed_const(24'h000000);
    feed_const(24'hFFFFFF);

    // Oversized width clamps; then shrink mid-row so the column saturates
    set_size(2047, 1);
    feed_const(24'h0F0F0F);
    feed_const(24'hF0F0F0);
    feed_const(24'h808080);
    set_size(3, 1);
    feed_const(24'h7F7F7F);

    // Tall frame, then shrink height mid-frame: row saturates to the last
    // row and the last column yields three beats
    set_size(2, 4096);
    feed_random(6);
    set_size(2, 2);
    feed_random(2);

    // Random phases: mostly whole small frames, some partial ones and shrinks
    while (random_px < RANDOM_PIXELS) begin
      frame_geom(w, h, c, r);
      at_start = (col_pos == 0 && row_pos == 0);
      case ($urandom_range(0, 19))
        0:       new_w = 0;
        1:       new_w = 2047;
        default: new_w = $urandom_range(1, 10);
      endcase
      // Widening mid-frame would read line entries never written
      if (!at_start && eff_size(new_w, MAX_W) > w)
        new_w = $urandom_range(1, (w < 10) ? w : 10);
      case ($urandom_range(0, 19))
        0:       new_h = 0;
        1:       new_h = 8191;
        default: new_h = $urandom_range(1, 6);
      endcase
      set_size(new_w, new_h);
      frame_geom(w, h, c, r);
      if (w * h > 64 || $urandom_range(0, 3) == 0) n = $urandom_range(1, 12);
      else n = pixels_to_frame_end() + $urandom_range(0, 1) * w * h;
      feed_random(n);
      random_px += n;
    end

    drain();
    $display("Summary: %0d pixels over %0d frame size settings, incl. clamped sizes",
             pushed_cnt, settings_cnt);
    $display("Summary: %0d result beats checked, %0d of them blurred interior pixels",
             checked_cnt, blurred_cnt);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
